[src/tgapr_pkg.sv]
package tgapr_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PALETTE = 2'd1,
    PH_PIXELS  = 2'd2,
    PH_IDLE    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PALETTE = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_FAIL    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_EXP_WIDTH  = 2'd0,
    REG_EXP_HEIGHT = 2'd1,
    REG_KEEP_PAL   = 2'd2
  } reg_idx_e;

  localparam int unsigned CfgWidth   = 13;
  localparam int unsigned HdrPosBits = 5;
  localparam logic [HdrPosBits-1:0] HdrLast     = 5'd17;
  localparam logic [HdrPosBits-1:0] HdrWidthLo  = 5'd12;
  localparam logic [HdrPosBits-1:0] HdrWidthHi  = 5'd13;
  localparam logic [HdrPosBits-1:0] HdrHeightLo = 5'd14;
  localparam logic [HdrPosBits-1:0] HdrHeightHi = 5'd15;
  localparam logic [7:0] PalLastIndex = 8'd255;
  localparam logic [1:0] ChanBlue     = 2'd0;
  localparam logic [1:0] ChanGreen    = 2'd1;
  localparam logic [1:0] ChanRed      = 2'd2;

  typedef struct packed {
    logic       check;
    logic [7:0] expected;
  } hdr_byte_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  palette_index;
    logic [1:0]  channel;
    logic [23:0] pixel_address;
    logic [7:0]  value;
    logic        last;
  } result_t;

  function automatic hdr_byte_t hdr_fixed(input logic [HdrPosBits-1:0] pos);
    hdr_byte_t r;
    r.check    = 1'b1;
    r.expected = 8'd0;
    case (pos)
      5'd1, 5'd2, 5'd6: r.expected = 8'd1;
      5'd3, 5'd4, 5'd5, 5'd8, 5'd9, 5'd10, 5'd11, 5'd17: r.expected = 8'd0;
      5'd7:  r.expected = 8'd24;
      5'd16: r.expected = 8'd8;
      default: r.check = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[src/tga_paletted_image_reader.sv]
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: byte_value[7:0]; tuser: start_of_file
// m_axis    out  tdata: palette_index, channel, pixel_address, value; tuser: kind;
//                tlast: last
// cfg       in   0 expected_width, 1 expected_height, 2 keep_palette
//
// One byte per cycle while s_axis_tready is high; each result is registered.
// The declared row base is formed by a registered 16x16 multiply during the
// palette bytes, so the pixel address is an add and a subtract per byte.
// Reset: header phase, expected size 16x16, palette skipped.
// An output register plus a skid stage; s_axis_tready drops only while the
// skid stage holds a result.
module tga_paletted_image_reader
  import tgapr_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // byte_value
  input  logic [0:0]          s_axis_tuser,   // start_of_file
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // palette_index, channel, pixel_address, value
  output logic [1:0]          m_axis_tuser,   // kind
  output logic                m_axis_tlast,   // last
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  logic [CfgWidth-1:0] exp_w_q, exp_h_q;
  logic                keep_pal_q;

  phase_e                phase_q, phase_d;
  logic [HdrPosBits-1:0] pos_q, pos_d;
  logic [15:0]           dw_q, dw_d, dh_q, dh_d;
  logic [7:0]            pidx_q, pidx_d;
  logic [1:0]            chan_q, chan_d;
  logic [CfgWidth-1:0]   col_q, col_d;
  logic [ADDR_BITS-1:0]  row_q, row_d;

  logic    accept;
  logic    start;
  phase_e  ph_e;
  logic [HdrPosBits-1:0] pos_e;
  logic [15:0] dw_e, dh_e;
  logic [CfgWidth-1:0]   col_e;
  logic [7:0]  b;

  hdr_byte_t   fx;
  logic        byte_ok;
  logic        size_ok;
  logic        hdr_ok;
  logic [15:0] dh_m1;
  logic [31:0] prod;
  logic        row_end;
  logic        is_last;
  logic        size_zero;
  logic [ADDR_BITS-1:0] addr_sum;
  logic [31:0] addr_ext;

  logic    res_valid;
  result_t res;
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_take;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign start  = s_axis_tuser[0];
  assign b      = s_axis_tdata;

  // state as seen after an optional restart
  assign ph_e  = start ? PH_HEADER : phase_q;
  assign pos_e = start ? '0 : pos_q;
  assign dw_e  = start ? '0 : dw_q;
  assign dh_e  = start ? '0 : dh_q;
  assign col_e = start ? '0 : col_q;

  assign fx      = hdr_fixed(pos_e);
  assign byte_ok = !fx.check || (b == fx.expected);
  assign size_ok = (dw_e == 16'(exp_w_q)) && (dh_e == 16'(exp_h_q));
  assign hdr_ok  = byte_ok && ((pos_e != HdrLast) || size_ok);

  assign dh_m1     = dh_q - 16'd1;
  assign prod      = dh_m1 * dw_q;
  assign size_zero = (dw_q == '0) || (dh_q == '0);
  assign row_end   = (16'(col_e) + 16'd1) >= dw_e;
  assign is_last   = row_end && (row_q == '0);
  assign addr_sum  = row_q + ADDR_BITS'(col_e);
  assign addr_ext  = 32'(addr_sum);

  // next state
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    dw_d    = dw_q;
    dh_d    = dh_q;
    pidx_d  = pidx_q;
    chan_d  = chan_q;
    col_d   = col_q;
    row_d   = row_q;
    if (phase_q == PH_PALETTE) begin
      row_d = ADDR_BITS'(prod);
    end
    if (accept) begin
      phase_d = ph_e;
      pos_d   = pos_e;
      dw_d    = dw_e;
      dh_d    = dh_e;
      col_d   = col_e;
      case (ph_e)
        PH_HEADER: begin
          if (pos_e == HdrWidthLo)  dw_d[7:0]  = b;
          if (pos_e == HdrWidthHi)  dw_d[15:8] = b;
          if (pos_e == HdrHeightLo) dh_d[7:0]  = b;
          if (pos_e == HdrHeightHi) dh_d[15:8] = b;
          if (!hdr_ok) begin
            phase_d = PH_IDLE;
          end else if (pos_e == HdrLast) begin
            phase_d = PH_PALETTE;
            pidx_d  = '0;
            chan_d  = ChanBlue;
            col_d   = '0;
          end else begin
            pos_d = pos_e + 5'd1;
          end
        end
        PH_PALETTE: begin
          if (chan_q == ChanRed) begin
            chan_d = ChanBlue;
            pidx_d = pidx_q + 8'd1;
            if (pidx_q == PalLastIndex) phase_d = PH_PIXELS;
          end else begin
            chan_d = chan_q + 2'd1;
          end
        end
        PH_PIXELS: begin
          if (size_zero) begin
            phase_d = PH_IDLE;
          end else if (is_last) begin
            phase_d = PH_IDLE;
          end else if (row_end) begin
            col_d = '0;
            row_d = row_q - ADDR_BITS'(dw_q);
          end else begin
            col_d = col_q + CfgWidth'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result
  always_comb begin
    res       = '0;
    res.kind  = KIND_PALETTE;
    res_valid = 1'b0;
    case (ph_e)
      PH_HEADER: begin
        if (!hdr_ok) begin
          res_valid = 1'b1;
          res.kind  = KIND_FAIL;
        end
      end
      PH_PALETTE: begin
        res_valid         = keep_pal_q;
        res.palette_index = pidx_q;
        res.channel       = chan_q;
        res.value         = {2'b00, b[7:2]};
      end
      PH_PIXELS: begin
        if (!size_zero) begin
          res_valid         = 1'b1;
          res.kind          = KIND_PIXEL;
          res.pixel_address = addr_ext[23:0];
          res.value         = b;
          res.last          = is_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      dw_q       <= '0;
      dh_q       <= '0;
      pidx_q     <= '0;
      chan_q     <= ChanBlue;
      col_q      <= '0;
      row_q      <= '0;
      exp_w_q    <= CfgWidth'(16);
      exp_h_q    <= CfgWidth'(16);
      keep_pal_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      dw_q    <= dw_d;
      dh_q    <= dh_d;
      pidx_q  <= pidx_d;
      chan_q  <= chan_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_EXP_WIDTH:  exp_w_q    <= cfg_wdata_i;
          REG_EXP_HEIGHT: exp_h_q    <= cfg_wdata_i;
          REG_KEEP_PAL:   keep_pal_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // output register with skid stage
  assign out_take      = out_valid_q && m_axis_tready;
  assign s_axis_tready = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (out_valid_q && !out_take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (accept && res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'd0, out_q.value, out_q.pixel_address, out_q.channel,
                          out_q.palette_index};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  a_last_only_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_PIXEL))
    else $error("last flag on a non-pixel result");

  a_hdr_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER) |-> (pos_q <= HdrLast))
    else $error("header position past header end");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PALETTE) |-> (chan_q != 2'd3))
    else $error("palette channel out of range");

  a_pixel_after_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS) |-> ($past(phase_q) == PH_PALETTE ||
                                $past(phase_q) == PH_PIXELS))
    else $error("pixel phase entered without palette");

endmodule
